[rtl/core/lsrd_pkg.sv]
// Package for the lockset race detector: sizes, codes, payload and control types.
`timescale 1ns / 1ps
package lsrd_pkg;

    // Table sizes
    localparam int LOCK_SLOTS     = 64;
    localparam int SHADOW_ENTRIES = 4096;
    localparam int REPORT_SLOTS   = 4096;
    localparam int THREADS        = 16;

    localparam int LK_AW = (LOCK_SLOTS > 1) ? $clog2(LOCK_SLOTS) : 1;
    localparam int SH_AW = $clog2(SHADOW_ENTRIES);
    localparam int RP_AW = $clog2(REPORT_SLOTS);
    localparam int TH_AW = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int PTR_W0 = (SH_AW > RP_AW) ? SH_AW + 1 : RP_AW + 1;
    localparam int PTR_W  = (PTR_W0 > LK_AW + 1) ? PTR_W0 : LK_AW + 1;

    // Field widths
    localparam int ADDR_W     = 48;
    localparam int WORD_W     = 45;
    localparam int SITE_W     = 32;
    localparam int TID_W      = 4;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [ADDR_W-1:0] HIGH_THR_RESET = 48'h7f00_0000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP      = 3'd3;

    typedef enum logic [2:0] {
        OP_ACCESS  = 3'd0,
        OP_ACQUIRE = 3'd1,
        OP_RELEASE = 3'd2,
        OP_TRESET  = 3'd3,
        OP_PSTART  = 3'd4
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_NEW    = 3'd1,
        ST_DUP    = 3'd2,
        ST_FILT   = 3'd3,
        ST_IGN    = 3'd4,
        ST_FULL   = 3'd5,
        ST_HALT   = 3'd6,
        ST_NOLOCK = 3'd7
    } t_status;

    typedef enum logic [1:0] {
        MODE_VIRGIN = 2'd0,
        MODE_EXCL   = 2'd1,
        MODE_SHARED = 2'd2,
        MODE_SHMOD  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        SEL_LOCK   = 2'd0,
        SEL_SHADOW = 2'd1,
        SEL_REPORT = 2'd2
    } t_srch_sel;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_LSRCH,
        S_LAPPLY,
        S_SSRCH,
        S_SAPPLY,
        S_SCHK,
        S_RSRCH,
        S_RAPPLY,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        opcode;
        logic [TID_W-1:0]  thread_id;
        logic [ADDR_W-1:0] address;
        logic [SITE_W-1:0] site_id;
        logic              write_op;
    } t_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [WORD_W-1:0] race_word;
        logic [SITE_W-1:0] earlier_site;
        logic              earlier_write;
        logic [TID_W-1:0]  earlier_thread;
    } t_out;

    // One shadow table entry
    typedef struct packed {
        logic [WORD_W-1:0]     word;
        t_mode                 mode;
        logic [TID_W-1:0]      owner;
        logic [LOCK_SLOTS-1:0] lockset;
        logic [SITE_W-1:0]     last_site;
        logic                  last_write;
        logic [TID_W-1:0]      last_thread;
        logic                  fired;
    } t_shadow;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      set_res;
        t_status   res_code;
        logic      set_parallel;
        logic      clear_mask;
        logic      srch_start;
        logic      srch_run;
        t_srch_sel sel;
        logic      lock_apply;
        logic      sh_new;
        logic      sh_update;
        logic      rpt_apply;
        logic      push;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] opcode;
        logic       enable;
        logic       halted;
        logic       parallel;
        logic       tid_ok;
        logic       srch_done;
        logic       found;
        logic       sh_full;
        logic       need_rpt;
        logic       out_free;
    } t_stat;

endpackage

[rtl/core/lsrd_ctrl.sv]
// Sequencer for the lockset race detector: decodes an item and steps the table scans.
`timescale 1ns / 1ps
module lsrd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lsrd_pkg::t_stat i_stat,
    output lsrd_pkg::t_cmd  o_cmd
);

    lsrd_pkg::t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lsrd_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lsrd_pkg::S_IDLE: begin
                if (i_in_valid) n_state = lsrd_pkg::S_DEC;
            end
            lsrd_pkg::S_DEC: begin
                n_state = lsrd_pkg::S_DONE;
                if (i_stat.enable && !i_stat.halted && i_stat.tid_ok) begin
                    case (i_stat.opcode)
                        lsrd_pkg::OP_ACCESS: begin
                            if (i_stat.parallel) n_state = lsrd_pkg::S_SSRCH;
                        end
                        lsrd_pkg::OP_ACQUIRE: n_state = lsrd_pkg::S_LSRCH;
                        lsrd_pkg::OP_RELEASE: n_state = lsrd_pkg::S_LSRCH;
                        default: n_state = lsrd_pkg::S_DONE;
                    endcase
                end
            end
            lsrd_pkg::S_LSRCH: begin
                if (i_stat.srch_done) n_state = lsrd_pkg::S_LAPPLY;
            end
            lsrd_pkg::S_LAPPLY: n_state = lsrd_pkg::S_DONE;
            lsrd_pkg::S_SSRCH: begin
                if (i_stat.srch_done) n_state = lsrd_pkg::S_SAPPLY;
            end
            lsrd_pkg::S_SAPPLY: n_state = lsrd_pkg::S_SCHK;
            lsrd_pkg::S_SCHK: begin
                n_state = i_stat.need_rpt ? lsrd_pkg::S_RSRCH : lsrd_pkg::S_DONE;
            end
            lsrd_pkg::S_RSRCH: begin
                if (i_stat.srch_done) n_state = lsrd_pkg::S_RAPPLY;
            end
            lsrd_pkg::S_RAPPLY: n_state = lsrd_pkg::S_DONE;
            lsrd_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = lsrd_pkg::S_IDLE;
            end
            default: n_state = lsrd_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd = '0;
        o_cmd.sel = lsrd_pkg::SEL_SHADOW;
        o_cmd.res_code = lsrd_pkg::ST_OK;
        o_in_ready = 1'b0;
        case (r_state)
            lsrd_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            lsrd_pkg::S_DEC: begin
                o_cmd.set_res = 1'b1;
                o_cmd.res_code = lsrd_pkg::ST_IGN;
                if (!i_stat.enable) begin
                    o_cmd.res_code = lsrd_pkg::ST_IGN;
                end else if (i_stat.halted) begin
                    o_cmd.res_code = lsrd_pkg::ST_HALT;
                end else if (i_stat.opcode == lsrd_pkg::OP_PSTART) begin
                    o_cmd.set_parallel = 1'b1;
                    o_cmd.res_code = lsrd_pkg::ST_OK;
                end else if (i_stat.tid_ok) begin
                    case (i_stat.opcode)
                        lsrd_pkg::OP_ACCESS: begin
                            if (i_stat.parallel) begin
                                o_cmd.set_res = 1'b0;
                                o_cmd.srch_start = 1'b1;
                                o_cmd.sel = lsrd_pkg::SEL_SHADOW;
                            end
                        end
                        lsrd_pkg::OP_ACQUIRE, lsrd_pkg::OP_RELEASE: begin
                            o_cmd.set_res = 1'b0;
                            o_cmd.srch_start = 1'b1;
                            o_cmd.sel = lsrd_pkg::SEL_LOCK;
                        end
                        lsrd_pkg::OP_TRESET: begin
                            o_cmd.clear_mask = 1'b1;
                            o_cmd.res_code = lsrd_pkg::ST_OK;
                        end
                        default: o_cmd.res_code = lsrd_pkg::ST_IGN;
                    endcase
                end
            end
            lsrd_pkg::S_LSRCH: begin
                o_cmd.srch_run = 1'b1;
                o_cmd.sel = lsrd_pkg::SEL_LOCK;
            end
            lsrd_pkg::S_LAPPLY: o_cmd.lock_apply = 1'b1;
            lsrd_pkg::S_SSRCH: begin
                o_cmd.srch_run = 1'b1;
                o_cmd.sel = lsrd_pkg::SEL_SHADOW;
            end
            lsrd_pkg::S_SAPPLY: begin
                if (i_stat.found) begin
                    o_cmd.sh_update = 1'b1;
                end else if (i_stat.sh_full) begin
                    o_cmd.set_res = 1'b1;
                    o_cmd.res_code = lsrd_pkg::ST_FULL;
                end else begin
                    o_cmd.sh_new = 1'b1;
                end
            end
            lsrd_pkg::S_SCHK: begin
                if (i_stat.need_rpt) begin
                    o_cmd.srch_start = 1'b1;
                    o_cmd.sel = lsrd_pkg::SEL_REPORT;
                end
            end
            lsrd_pkg::S_RSRCH: begin
                o_cmd.srch_run = 1'b1;
                o_cmd.sel = lsrd_pkg::SEL_REPORT;
            end
            lsrd_pkg::S_RAPPLY: o_cmd.rpt_apply = 1'b1;
            lsrd_pkg::S_DONE: o_cmd.push = i_stat.out_free;
            default: o_cmd.push = 1'b0;
        endcase
    end

endmodule

[rtl/core/lsrd_dp.sv]
// Datapath for the lockset race detector: registers, lock/shadow/report tables and scan.
`timescale 1ns / 1ps
module lsrd_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lsrd_pkg::t_in                       i_in_data,
    input  logic                                i_cfg_valid,
    input  logic [lsrd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lsrd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output lsrd_pkg::t_out                      o_out_data,
    input  lsrd_pkg::t_cmd                      i_cmd,
    output lsrd_pkg::t_stat                     o_stat
);

    localparam int LS = lsrd_pkg::LOCK_SLOTS;
    localparam int PW = lsrd_pkg::PTR_W;

    // Configuration
    logic                        r_en, r_skip, r_stop;
    logic [lsrd_pkg::ADDR_W-1:0] r_thr;

    // Global state
    logic r_halted, r_par;
    logic [LS-1:0] r_masks [lsrd_pkg::THREADS];
    logic [lsrd_pkg::LK_AW:0] r_lk_cnt;
    logic [lsrd_pkg::SH_AW:0] r_sh_cnt;
    logic [lsrd_pkg::RP_AW:0] r_rp_cnt;

    // Tables
    logic [lsrd_pkg::ADDR_W-1:0] lk_mem [LS];
    lsrd_pkg::t_shadow           sh_mem [lsrd_pkg::SHADOW_ENTRIES];
    logic [lsrd_pkg::KEY_W-1:0]  rp_mem [lsrd_pkg::REPORT_SLOTS];
    logic [lsrd_pkg::ADDR_W-1:0] r_lk_rd;
    lsrd_pkg::t_shadow           r_sh_rd;
    logic [lsrd_pkg::KEY_W-1:0]  r_rp_rd;

    // Item, scan and result registers
    lsrd_pkg::t_in              r_item;
    logic [PW-1:0]              r_ptr, r_pidx;
    logic                       r_pend, r_found, r_need;
    logic [lsrd_pkg::KEY_W-1:0] r_rkey;
    lsrd_pkg::t_out             r_race, r_res, r_out;
    logic                       r_ovalid;

    logic [lsrd_pkg::TH_AW-1:0] tidx;
    logic [LS-1:0]              held, bitmask;
    logic [PW-1:0]              count_sel;
    logic                       match, hit, rd_en, done;
    logic                       lk_full, lk_ok;
    logic [lsrd_pkg::LK_AW-1:0] lk_bit;

    // Shadow update
    lsrd_pkg::t_shadow          e, upd, fresh;
    logic [LS-1:0]              new_ls;
    logic                       fire, filtered, sh_we;
    logic [lsrd_pkg::SH_AW-1:0] sh_waddr;
    lsrd_pkg::t_shadow          sh_wdata;
    logic [lsrd_pkg::SITE_W-1:0] lo_site, hi_site;
    lsrd_pkg::t_out             race;

    assign tidx = lsrd_pkg::TH_AW'(r_item.thread_id);
    assign held = r_masks[tidx];

    // Scan over the selected table, one entry per cycle
    always_comb begin
        case (i_cmd.sel)
            lsrd_pkg::SEL_LOCK: begin
                count_sel = PW'(r_lk_cnt);
                match = (r_lk_rd == r_item.address);
            end
            lsrd_pkg::SEL_REPORT: begin
                count_sel = PW'(r_rp_cnt);
                match = (r_rp_rd == r_rkey);
            end
            default: begin
                count_sel = PW'(r_sh_cnt);
                match = (r_sh_rd.word == r_item.address[lsrd_pkg::ADDR_W-1:3]);
            end
        endcase
    end

    assign hit   = r_pend && match;
    assign rd_en = i_cmd.srch_run && !hit && (r_ptr < count_sel);
    assign done  = hit || (!r_pend && (r_ptr >= count_sel));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
        end else if (i_cmd.srch_start) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.srch_run) begin
            if (!hit) begin
                r_pend <= rd_en;
                if (rd_en) begin
                    r_ptr <= r_ptr + PW'(1);
                end
            end
            if (done) r_found <= hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) r_pidx <= r_ptr;
    end

    // Lock registry
    assign lk_full = (r_lk_cnt >= (lsrd_pkg::LK_AW + 1)'(LS));
    assign lk_ok   = r_found || !lk_full;
    assign lk_bit  = r_found ? r_pidx[lsrd_pkg::LK_AW-1:0] : r_lk_cnt[lsrd_pkg::LK_AW-1:0];
    assign bitmask = {{(LS-1){1'b0}}, 1'b1} << lk_bit;

    always_ff @(posedge i_clk) begin
        if (i_cmd.lock_apply && !r_found && !lk_full) begin
            lk_mem[r_lk_cnt[lsrd_pkg::LK_AW-1:0]] <= r_item.address;
        end
        if (rd_en && i_cmd.sel == lsrd_pkg::SEL_LOCK) begin
            r_lk_rd <= lk_mem[r_ptr[lsrd_pkg::LK_AW-1:0]];
        end
    end

    // Shadow state transition
    always_comb begin
        e = r_sh_rd;
        upd = e;
        new_ls = e.lockset;
        fire = 1'b0;
        case (e.mode)
            lsrd_pkg::MODE_EXCL: begin
                if (r_item.thread_id != e.owner) begin
                    new_ls = held;
                    if (r_item.write_op || e.last_write) begin
                        upd.mode = lsrd_pkg::MODE_SHMOD;
                        fire = (held == '0);
                    end else begin
                        upd.mode = lsrd_pkg::MODE_SHARED;
                    end
                end
            end
            lsrd_pkg::MODE_SHARED: begin
                new_ls = e.lockset & held;
                if (r_item.write_op) begin
                    upd.mode = lsrd_pkg::MODE_SHMOD;
                    fire = (new_ls == '0);
                end
            end
            lsrd_pkg::MODE_SHMOD: begin
                new_ls = e.lockset & held;
                fire = (new_ls == '0);
            end
            default: begin
                upd.mode = lsrd_pkg::MODE_EXCL;
                upd.owner = r_item.thread_id;
            end
        endcase
        upd.lockset = new_ls;
        upd.last_site = r_item.site_id;
        upd.last_write = r_item.write_op;
        upd.last_thread = r_item.thread_id;
        upd.fired = fire;

        fresh.word = r_item.address[lsrd_pkg::ADDR_W-1:3];
        fresh.mode = lsrd_pkg::MODE_EXCL;
        fresh.owner = r_item.thread_id;
        fresh.lockset = '0;
        fresh.last_site = r_item.site_id;
        fresh.last_write = r_item.write_op;
        fresh.last_thread = r_item.thread_id;
        fresh.fired = 1'b0;

        filtered = (r_item.thread_id == e.last_thread)
                || (!r_item.write_op && !e.last_write)
                || (r_skip && ({r_item.address[lsrd_pkg::ADDR_W-1:3], 3'b000} >= r_thr));

        race.status = lsrd_pkg::ST_FILT;
        race.race_word = r_item.address[lsrd_pkg::ADDR_W-1:3];
        race.earlier_site = e.last_site;
        race.earlier_write = e.last_write;
        race.earlier_thread = e.last_thread;

        // Sorted site pair
        if (e.last_site < r_item.site_id) begin
            lo_site = e.last_site;
            hi_site = r_item.site_id;
        end else begin
            lo_site = r_item.site_id;
            hi_site = e.last_site;
        end
    end

    assign sh_we    = i_cmd.sh_new || (i_cmd.sh_update && !r_sh_rd.fired);
    assign sh_waddr = i_cmd.sh_new ? r_sh_cnt[lsrd_pkg::SH_AW-1:0]
                                   : r_pidx[lsrd_pkg::SH_AW-1:0];
    assign sh_wdata = i_cmd.sh_new ? fresh : upd;

    always_ff @(posedge i_clk) begin
        if (sh_we) sh_mem[sh_waddr] <= sh_wdata;
        if (rd_en && i_cmd.sel == lsrd_pkg::SEL_SHADOW) begin
            r_sh_rd <= sh_mem[r_ptr[lsrd_pkg::SH_AW-1:0]];
        end
    end

    // Report table
    always_ff @(posedge i_clk) begin
        if (i_cmd.rpt_apply && !r_found
            && (r_rp_cnt < (lsrd_pkg::RP_AW + 1)'(lsrd_pkg::REPORT_SLOTS))) begin
            rp_mem[r_rp_cnt[lsrd_pkg::RP_AW-1:0]] <= r_rkey;
        end
        if (rd_en && i_cmd.sel == lsrd_pkg::SEL_REPORT) begin
            r_rp_rd <= rp_mem[r_ptr[lsrd_pkg::RP_AW-1:0]];
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en     <= 1'b0;
            r_skip   <= 1'b1;
            r_thr    <= lsrd_pkg::HIGH_THR_RESET;
            r_stop   <= 1'b1;
            r_halted <= 1'b0;
            r_par    <= 1'b0;
            r_lk_cnt <= '0;
            r_sh_cnt <= '0;
            r_rp_cnt <= '0;
            r_need   <= 1'b0;
            r_ovalid <= 1'b0;
            for (int t = 0; t < lsrd_pkg::THREADS; t++) begin
                r_masks[t] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lsrd_pkg::CFG_ENABLE:    r_en   <= i_cfg_data[0];
                    lsrd_pkg::CFG_SKIP_HIGH: r_skip <= i_cfg_data[0];
                    lsrd_pkg::CFG_HIGH_THR:  r_thr  <= i_cfg_data;
                    lsrd_pkg::CFG_STOP:      r_stop <= i_cfg_data[0];
                    default: r_en <= r_en;
                endcase
            end
            if (i_cmd.set_parallel) r_par <= 1'b1;
            if (i_cmd.clear_mask) r_masks[tidx] <= '0;
            if (i_cmd.lock_apply && lk_ok) begin
                if (r_item.opcode == lsrd_pkg::OP_ACQUIRE) begin
                    r_masks[tidx] <= held | bitmask;
                end else begin
                    r_masks[tidx] <= held & ~bitmask;
                end
                if (!r_found) r_lk_cnt <= r_lk_cnt + 1'b1;
            end
            if (i_cmd.sh_new) r_sh_cnt <= r_sh_cnt + 1'b1;
            if (i_cmd.set_res || i_cmd.sh_new) r_need <= 1'b0;
            if (i_cmd.sh_update) r_need <= !r_sh_rd.fired && fire && !filtered;
            if (i_cmd.rpt_apply && !r_found) begin
                if (r_rp_cnt < (lsrd_pkg::RP_AW + 1)'(lsrd_pkg::REPORT_SLOTS)) begin
                    r_rp_cnt <= r_rp_cnt + 1'b1;
                end
                if (r_stop) r_halted <= 1'b1;
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_in_data;
        if (i_cmd.set_res) r_res <= '{status: i_cmd.res_code, default: '0};
        if (i_cmd.lock_apply) begin
            r_res <= '{status: (lk_ok ? lsrd_pkg::ST_OK : lsrd_pkg::ST_NOLOCK), default: '0};
        end
        if (i_cmd.sh_new) r_res <= '{status: lsrd_pkg::ST_OK, default: '0};
        if (i_cmd.sh_update) begin
            if (!r_sh_rd.fired && fire && filtered) begin
                r_res <= race;
            end else begin
                r_res <= '{status: lsrd_pkg::ST_OK, default: '0};
            end
            r_race <= race;
            r_rkey <= {hi_site, lo_site};
        end
        if (i_cmd.rpt_apply) begin
            r_res <= '{status: (r_found ? lsrd_pkg::ST_DUP : lsrd_pkg::ST_NEW),
                       race_word: r_race.race_word,
                       earlier_site: r_race.earlier_site,
                       earlier_write: r_race.earlier_write,
                       earlier_thread: r_race.earlier_thread};
        end
        if (i_cmd.push) r_out <= r_res;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    // Status to the controller
    always_comb begin
        o_stat.opcode    = r_item.opcode;
        o_stat.enable    = r_en;
        o_stat.halted    = r_halted;
        o_stat.parallel  = r_par;
        o_stat.tid_ok    = (32'(r_item.thread_id) < 32'(lsrd_pkg::THREADS));
        o_stat.srch_done = done;
        o_stat.found     = r_found;
        o_stat.sh_full   = (r_sh_cnt >= (lsrd_pkg::SH_AW + 1)'(lsrd_pkg::SHADOW_ENTRIES));
        o_stat.need_rpt  = r_need;
        o_stat.out_free  = !r_ovalid || i_out_ready;
    end

endmodule

[rtl/core/lockset_race_detector.sv]
// Top level of the lockset race detector: sequencer, datapath and assertions.
// Each item runs to completion before the next is taken; a finished result sits in an
// output register so the next item can enter while it waits. Enable-off, halted, thread
// reset and parallel start items go from decode straight to done. Lock acquire/release
// scans the lock registry one entry per cycle. An access in parallel mode scans the
// shadow table one entry per cycle, and a race that survives filtering then scans the
// report table. These single-port table scans set the rate. Configuration writes are
// always accepted.
`timescale 1ns / 1ps
module lockset_race_detector (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  lsrd_pkg::t_in                   i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output lsrd_pkg::t_out                  o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [lsrd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lsrd_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    lsrd_pkg::t_cmd  cmd;
    lsrd_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    lsrd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lsrd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_stat      (stat)
    );

    // One item in flight: no second accept right after one
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("item accepted while another is in flight");

    // Results without a race carry zero race fields
    a_clean_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.status == lsrd_pkg::ST_OK
            || o_out_data.status == lsrd_pkg::ST_IGN
            || o_out_data.status == lsrd_pkg::ST_FULL
            || o_out_data.status == lsrd_pkg::ST_HALT
            || o_out_data.status == lsrd_pkg::ST_NOLOCK))
        |-> (o_out_data.race_word == '0 && o_out_data.earlier_site == '0
            && !o_out_data.earlier_write && o_out_data.earlier_thread == '0))
        else $error("race fields set on a result without a race");

    // A result is pushed only into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> stat.out_free)
        else $error("result pushed over a pending one");

    // Accept is never followed by a push on the next edge
    a_no_early_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !cmd.push)
        else $error("result pushed before decode");

endmodule
